[src/brac_pkg.sv]
// Shared constants and pipeline stage numbering for the bearing and range core.
package brac_pkg;

  // Pipeline depth and divider layout
  localparam int unsigned NumStages       = 11;
  localparam int unsigned StageAbs        = 0;
  localparam int unsigned StageSort       = 1;
  localparam int unsigned DivBitsPerStage = 3;
  localparam int unsigned DivFirstStage   = 2;
  localparam int unsigned DivStages       = 5;
  localparam int unsigned StageDiff       = DivFirstStage + DivStages;
  localparam int unsigned StageSlope      = StageDiff + 1;
  localparam int unsigned StageScale      = StageSlope + 1;
  localparam int unsigned StageMap        = StageScale + 1;

  // Number formats
  localparam int unsigned QShift = 14;
  localparam int unsigned QuoW   = QShift + 1;
  localparam int unsigned MagW   = 16;
  localparam int unsigned RemW   = MagW + 1;
  localparam int unsigned DistW  = 15;

  // Arctangent fit
  localparam logic [13:0] FitBase  = 14'h2800;
  localparam logic [14:0] FitKnee  = 15'h1333;
  localparam logic [11:0] FitSlope = 12'hB00;

  localparam logic [DistW-1:0] DistMax = 15'h7FFF;

  // Cardinal bearings
  localparam logic [15:0] AngleNorth = 16'h0000;
  localparam logic [15:0] AngleEast  = 16'h4000;
  localparam logic [15:0] AngleSouth = 16'h8000;
  localparam logic [15:0] AngleWest  = 16'hC000;

endpackage

[src/bearing_and_range_approx_core.sv]
// Top level: pipelined bearing and approximate range of a 2-D offset vector.
//
// Input channel: in_valid_i / in_ready_o carry one beat of (delta_x_i, delta_y_i),
// signed 16-bit offsets. Output channel: out_valid_o / out_ready_i carry one beat
// of bearing_o (binary angle, 0 = +y, 0x4000 = +x, clockwise) and distance_o
// (larger magnitude plus half the smaller, saturated at 32767).
//
// Throughput: one beat per cycle while the receiver takes beats; the eleven
// register stages are magnitude, sort/range, five radix-8 restoring divider
// stages (three quotient bits each) for the Q14 ratio, fit difference, slope
// multiply, scale multiply, and octant map into the output register.
//
// Every stage carries a valid bit. A stage takes new data when it is empty or
// the stage after it moves, so bubbles close up while the receiver stalls and
// the input keeps being accepted until every stage holds a beat. A stalled
// output beat holds with its payload unchanged.
//
// Reset clears all valid bits; no output beat appears until one is accepted.
module bearing_and_range_approx_core
  import brac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [15:0] delta_x_i,
  input  logic signed [15:0] delta_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       bearing_o,
  output logic [DistW-1:0]  distance_o
);

  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic             zero_x;
    logic             zero_y;
    logic             swapped;
    logic [MagW-1:0]  mag_x;
    logic [MagW-1:0]  mag_y;
    logic [MagW-1:0]  hi;
    logic [RemW-1:0]  rem;
    logic [QuoW-1:0]  quo;
    logic [DistW-1:0] len;
    logic [13:0]      diff;
    logic [25:0]      prod;
    logic [28:0]      acc;
    logic [15:0]      bearing;
  } pipe_t;

  pipe_t                 pipe_q [NumStages];
  pipe_t                 pipe_d [NumStages];
  logic [NumStages-1:0]  valid_q;
  logic [NumStages-1:0]  adv;

  // Stage k moves when it is empty or the next one moves; the last one moves
  // when its beat is taken.
  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_comb begin
    logic [RemW-1:0]  r;
    logic [QuoW-1:0]  q;
    logic [16:0]      sum;
    logic [MagW-1:0]  lo;
    logic [13:0]      coef;
    logic [15:0]      angle;
    int unsigned      j;

    r     = '0;
    q     = '0;
    sum   = '0;
    lo    = '0;
    coef  = '0;
    angle = '0;
    j     = 0;

    // Magnitudes and axis flags straight from the input beat
    pipe_d[StageAbs]        = '0;
    pipe_d[StageAbs].neg_x  = delta_x_i[15];
    pipe_d[StageAbs].neg_y  = delta_y_i[15];
    pipe_d[StageAbs].zero_x = (delta_x_i == '0);
    pipe_d[StageAbs].zero_y = (delta_y_i == '0);
    pipe_d[StageAbs].mag_x  = delta_x_i[15] ? (~delta_x_i + 16'd1) : delta_x_i;
    pipe_d[StageAbs].mag_y  = delta_y_i[15] ? (~delta_y_i + 16'd1) : delta_y_i;

    // Order the magnitudes, seed the divider, form the range
    pipe_d[StageSort]         = pipe_q[StageSort-1];
    pipe_d[StageSort].swapped = pipe_q[StageSort-1].mag_x > pipe_q[StageSort-1].mag_y;
    if (pipe_d[StageSort].swapped) begin
      lo                   = pipe_q[StageSort-1].mag_y;
      pipe_d[StageSort].hi = pipe_q[StageSort-1].mag_x;
    end else begin
      lo                   = pipe_q[StageSort-1].mag_x;
      pipe_d[StageSort].hi = pipe_q[StageSort-1].mag_y;
    end
    pipe_d[StageSort].rem = {1'b0, lo};
    pipe_d[StageSort].quo = '0;
    sum = {1'b0, pipe_d[StageSort].hi} + {2'b0, lo[MagW-1:1]};
    pipe_d[StageSort].len = (sum > {2'b0, DistMax}) ? DistMax : sum[DistW-1:0];

    // Restoring divider: ratio = (lo << 14) / hi, three quotient bits a stage
    for (int k = 0; k < DivStages; k++) begin
      pipe_d[DivFirstStage+k] = pipe_q[DivFirstStage+k-1];
      r = pipe_q[DivFirstStage+k-1].rem;
      q = pipe_q[DivFirstStage+k-1].quo;
      for (int t = 0; t < DivBitsPerStage; t++) begin
        j = k * DivBitsPerStage + t;
        if (j != 0) begin
          r = {r[RemW-2:0], 1'b0};
        end
        if (r >= {1'b0, pipe_q[DivFirstStage+k-1].hi}) begin
          r = r - {1'b0, pipe_q[DivFirstStage+k-1].hi};
          q[QuoW-1-j] = 1'b1;
        end
      end
      pipe_d[DivFirstStage+k].rem = r;
      pipe_d[DivFirstStage+k].quo = q;
    end

    // Distance of the ratio from the fit knee
    pipe_d[StageDiff] = pipe_q[StageDiff-1];
    if (pipe_q[StageDiff-1].quo > FitKnee) begin
      q = pipe_q[StageDiff-1].quo - FitKnee;
    end else begin
      q = FitKnee - pipe_q[StageDiff-1].quo;
    end
    pipe_d[StageDiff].diff = q[13:0];

    // Slope term
    pipe_d[StageSlope]      = pipe_q[StageSlope-1];
    pipe_d[StageSlope].prod = 26'(pipe_q[StageSlope-1].diff * FitSlope);

    // Scale the fitted gain by the ratio
    pipe_d[StageScale]     = pipe_q[StageScale-1];
    coef = FitBase - {2'b0, pipe_q[StageScale-1].prod[25:QShift]};
    pipe_d[StageScale].acc = 29'(coef * pipe_q[StageScale-1].quo);

    // Place the angle in its octant; axes take cardinal bearings
    pipe_d[StageMap] = pipe_q[StageMap-1];
    angle = {2'b0, pipe_q[StageMap-1].acc[27:QShift]};
    if (pipe_q[StageMap-1].zero_x) begin
      pipe_d[StageMap].bearing =
        (!pipe_q[StageMap-1].neg_y && !pipe_q[StageMap-1].zero_y) ? AngleNorth : AngleSouth;
    end else if (pipe_q[StageMap-1].zero_y) begin
      pipe_d[StageMap].bearing = pipe_q[StageMap-1].neg_x ? AngleWest : AngleEast;
    end else if (!pipe_q[StageMap-1].neg_x) begin
      if (!pipe_q[StageMap-1].neg_y) begin
        pipe_d[StageMap].bearing = pipe_q[StageMap-1].swapped ? AngleEast - angle : angle;
      end else begin
        pipe_d[StageMap].bearing =
          pipe_q[StageMap-1].swapped ? AngleEast + angle : AngleSouth - angle;
      end
    end else begin
      if (!pipe_q[StageMap-1].neg_y) begin
        pipe_d[StageMap].bearing =
          pipe_q[StageMap-1].swapped ? AngleWest + angle : AngleNorth - angle;
      end else begin
        pipe_d[StageMap].bearing =
          pipe_q[StageMap-1].swapped ? AngleWest - angle : AngleSouth + angle;
      end
    end
  end

  // Valid bits: each stage takes the valid of the one before when it moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Payload: load on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (adv[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign bearing_o   = pipe_q[NumStages-1].bearing;
  assign distance_o  = pipe_q[NumStages-1].len;

endmodule

[src/brac_checker.sv]
// Port checker for the bearing and range core, bound to the top level.
module brac_checker
  import brac_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic signed [15:0] delta_x_i,
  input logic signed [15:0] delta_y_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [15:0]       bearing_o,
  input logic [DistW-1:0]  distance_o
);

  // A stalled output beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(bearing_o) && $stable(distance_o))
    else $error("output payload changed while stalled");

  // A receiver that takes the beat frees the whole pipeline for new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output is drained");

  // A full pipeline stays full until the receiver takes a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o || out_ready_i)
    else $error("pipeline space appeared without an output beat");

endmodule

bind bearing_and_range_approx_core brac_checker u_brac_checker (.*);
